[hdl/brd_pkg.sv]
// Shared types, constants and helpers for the run-length-8 bitmap decoder.
// No dependencies; used by the parser, the result queue and the top level.
package brd_pkg;

  // Largest image side the decoder handles, and the cursor saturation value.
  localparam int unsigned MAX_DIM    = 4096;
  localparam int unsigned DIM_W      = 13;
  localparam int unsigned COORD_W    = 12;
  localparam logic [DIM_W-1:0] DIM_LIMIT  = DIM_W'(MAX_DIM);
  localparam logic [DIM_W-1:0] CURSOR_MAX = '1;

  // Result queue depth between the parser and the output side.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes (byte address is 4 * index).
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  // Escape codes that follow a zero count byte.
  localparam logic [7:0] ESC_END_OF_LINE   = 8'd0;
  localparam logic [7:0] ESC_END_OF_BITMAP = 8'd1;
  localparam logic [7:0] ESC_DELTA         = 8'd2;

  // Parse phase, one-hot.
  typedef enum logic [5:0] {
    PH_COUNT   = 6'b000001,
    PH_VALUE   = 6'b000010,
    PH_DX      = 6'b000100,
    PH_DY      = 6'b001000,
    PH_LITERAL = 6'b010000,
    PH_PAD     = 6'b100000
  } phase_t;

  // One result transaction.
  typedef struct packed {
    logic [COORD_W-1:0] run_x;
    logic [COORD_W-1:0] run_row;
    logic [7:0]         run_length;
    logic [7:0]         pixel_index;
    logic               finished;
  } result_t;

  // Saturating cursor add.
  function automatic logic [DIM_W-1:0] sat_add(input logic [DIM_W-1:0] a,
                                               input logic [7:0] b);
    logic [DIM_W:0] sum;
    sum = {1'b0, a} + {{(DIM_W-7){1'b0}}, b};
    return sum[DIM_W] ? CURSOR_MAX : sum[DIM_W-1:0];
  endfunction

  // Clamp a configured dimension to MAX_DIM.
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] r);
    return (r > DIM_LIMIT) ? DIM_LIMIT : r;
  endfunction

endpackage

[hdl/brd_parser.sv]
// Front end of the decoder: parses one byte per accepted transaction,
// keeps the cursor and phase, and pushes run results. Depends on brd_pkg.
module brd_parser (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     accept,
  input  logic [7:0]               data_byte,
  input  logic                     start_of_image,
  input  logic                     last_byte,
  input  logic [brd_pkg::DIM_W-1:0] image_width,
  input  logic [brd_pkg::DIM_W-1:0] image_height,
  output logic                     push,
  output brd_pkg::result_t         result
);

  brd_pkg::phase_t              phase, phase_next;
  logic [brd_pkg::DIM_W-1:0]    cursor_x, cursor_x_next;
  logic [brd_pkg::DIM_W-1:0]    cursor_row, cursor_row_next;
  logic [7:0]                   held_count, held_count_next;
  logic [7:0]                   literal_left, literal_left_next;
  logic                         pad_pending, pad_pending_next;
  logic                         decode_done, decode_done_next;

  // State as seen by this byte, after an optional start-of-image clear.
  brd_pkg::phase_t              ph;
  logic [brd_pkg::DIM_W-1:0]    cx, cr, w, h, room;
  logic [7:0]                   hc, ll, ll_dec, n;
  logic                         pp, dn, fin, wr;

  always_comb begin
    ph     = start_of_image ? brd_pkg::PH_COUNT : phase;
    cx     = start_of_image ? '0 : cursor_x;
    cr     = start_of_image ? '0 : cursor_row;
    hc     = start_of_image ? '0 : held_count;
    ll     = start_of_image ? '0 : literal_left;
    pp     = start_of_image ? 1'b0 : pad_pending;
    dn     = start_of_image ? 1'b0 : decode_done;
    w      = brd_pkg::eff_dim(image_width);
    h      = brd_pkg::eff_dim(image_height);
    room   = w - cx;
    n      = ({5'b0, hc} < room) ? hc : room[7:0];
    ll_dec = (ll != 8'd0) ? ll - 8'd1 : 8'd0;

    phase_next        = ph;
    cursor_x_next     = cx;
    cursor_row_next   = cr;
    held_count_next   = hc;
    literal_left_next = ll;
    pad_pending_next  = pp;
    decode_done_next  = dn;
    fin               = 1'b0;
    wr                = 1'b0;
    result            = '0;

    if (!dn) begin
      if (cr >= h) begin
        fin = 1'b1;
      end else begin
        case (ph)
          brd_pkg::PH_COUNT: begin
            held_count_next = data_byte;
            phase_next      = brd_pkg::PH_VALUE;
          end
          brd_pkg::PH_VALUE: begin
            phase_next = brd_pkg::PH_COUNT;
            if (hc != 8'd0) begin
              // Encoded run, clipped to the row width.
              if (cx < w) begin
                wr                 = 1'b1;
                result.run_length  = n;
                result.pixel_index = data_byte;
                cursor_x_next      = cx + {5'b0, n};
              end
            end else if (data_byte == brd_pkg::ESC_END_OF_LINE) begin
              cursor_x_next   = '0;
              cursor_row_next = brd_pkg::sat_add(cr, 8'd1);
              fin             = (brd_pkg::sat_add(cr, 8'd1) >= h);
            end else if (data_byte == brd_pkg::ESC_END_OF_BITMAP) begin
              fin = 1'b1;
            end else if (data_byte == brd_pkg::ESC_DELTA) begin
              phase_next = brd_pkg::PH_DX;
            end else begin
              literal_left_next = data_byte;
              pad_pending_next  = data_byte[0];
              phase_next        = brd_pkg::PH_LITERAL;
            end
          end
          brd_pkg::PH_DX: begin
            held_count_next = data_byte;
            phase_next      = brd_pkg::PH_DY;
          end
          brd_pkg::PH_DY: begin
            cursor_x_next   = brd_pkg::sat_add(cx, hc);
            cursor_row_next = brd_pkg::sat_add(cr, data_byte);
            phase_next      = brd_pkg::PH_COUNT;
            fin             = (brd_pkg::sat_add(cr, data_byte) >= h);
          end
          brd_pkg::PH_LITERAL: begin
            // Literal bytes past the row width are consumed silently.
            if (cx < w) begin
              wr                 = 1'b1;
              result.run_length  = 8'd1;
              result.pixel_index = data_byte;
              cursor_x_next      = cx + brd_pkg::DIM_W'(1);
            end
            literal_left_next = ll_dec;
            if (ll_dec == 8'd0) begin
              phase_next = pp ? brd_pkg::PH_PAD : brd_pkg::PH_COUNT;
            end
          end
          default: begin
            pad_pending_next = 1'b0;
            phase_next       = brd_pkg::PH_COUNT;
          end
        endcase
      end
      if (last_byte) begin
        fin = 1'b1;
      end
      if (fin) begin
        decode_done_next = 1'b1;
      end
    end

    if (wr) begin
      result.run_x   = cx[brd_pkg::COORD_W-1:0];
      result.run_row = cr[brd_pkg::COORD_W-1:0];
    end
    result.finished = fin;
    push            = accept && !dn && (wr || fin);
  end

  // Parser state advances once per accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= brd_pkg::PH_COUNT;
      cursor_x     <= '0;
      cursor_row   <= '0;
      held_count   <= '0;
      literal_left <= '0;
      pad_pending  <= 1'b0;
      decode_done  <= 1'b0;
    end else if (accept) begin
      phase        <= phase_next;
      cursor_x     <= cursor_x_next;
      cursor_row   <= cursor_row_next;
      held_count   <= held_count_next;
      literal_left <= literal_left_next;
      pad_pending  <= pad_pending_next;
      decode_done  <= decode_done_next;
    end
  end

  // A finishing result leaves the parser done.
  a_fin_sets_done: assert property (@(posedge clk) disable iff (rst)
    push && result.finished |=> decode_done)
    else $error("finishing result did not set decode_done");

  // Once done, nothing is pushed until a start of image.
  a_done_quiet: assert property (@(posedge clk) disable iff (rst)
    decode_done && accept && !start_of_image |-> !push)
    else $error("result pushed after decoding finished");

endmodule

[hdl/brd_queue.sv]
// Back end of the decoder: a short result queue that drives the output
// channel, so the parser and the consumer stall independently. Depends on brd_pkg.
module brd_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  brd_pkg::result_t push_data,
  output logic             full,
  output logic             out_valid,
  input  logic             out_stall,
  output brd_pkg::result_t head
);

  brd_pkg::result_t               entries [brd_pkg::QUEUE_DEPTH];
  logic [brd_pkg::QPTR_W-1:0]     wr_ptr, rd_ptr;
  logic [brd_pkg::QCNT_W-1:0]     count;
  logic                           pop;

  assign full      = (count == brd_pkg::QCNT_W'(brd_pkg::QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign pop       = out_valid && !out_stall;
  assign head      = entries[rd_ptr];

  // Entry storage; payload needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + brd_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + brd_pkg::QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + brd_pkg::QCNT_W'(1);
        2'b01:   count <= count - brd_pkg::QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("push into a full result queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= brd_pkg::QCNT_W'(brd_pkg::QUEUE_DEPTH))
    else $error("result queue count out of range");

  a_push_shows: assert property (@(posedge clk) disable iff (rst)
    push |=> out_valid)
    else $error("pushed result not visible at the output");

endmodule

[hdl/bmp_rle8_decoder_top.sv]
// Top level of the run-length-8 bitmap decoder: configuration registers,
// parser front end and result queue. Depends on brd_pkg, brd_parser, brd_queue.
//
// The decoder takes one compressed byte per clock cycle while in_stall is low
// and produces at most one run result per byte, queued when the byte is
// accepted. The parser updates the cursor and parse phase once per accepted
// byte; a two-entry result queue sits between the parser and the output, so
// input bytes keep flowing while a result waits to be taken, and in_stall
// rises only when both queue entries are occupied. The user writes image_width
// (address 0) and image_height (address 4) through the APB port only while the
// decoder is idle; the block does not enforce this. Values above 4096 act as 4096.
module bmp_rle8_decoder_top (
  input  logic        clk,
  input  logic        rst,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input byte channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        start_of_image,
  input  logic        last_byte,
  // Result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] run_x,
  output logic [11:0] run_row,
  output logic [7:0]  run_length,
  output logic [7:0]  pixel_index,
  output logic        finished
);

  logic [brd_pkg::DIM_W-1:0] image_width, image_height;
  logic                      cfg_write, accept, push, full;
  brd_pkg::result_t          result, head;

  // Configuration registers.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= brd_pkg::DIM_W'(1);
      image_height <= brd_pkg::DIM_W'(1);
    end else if (cfg_write) begin
      case (paddr[2])
        brd_pkg::REG_IMAGE_WIDTH:  image_width  <= pwdata[brd_pkg::DIM_W-1:0];
        brd_pkg::REG_IMAGE_HEIGHT: image_height <= pwdata[brd_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      brd_pkg::REG_IMAGE_WIDTH:  prdata = {19'b0, image_width};
      brd_pkg::REG_IMAGE_HEIGHT: prdata = {19'b0, image_height};
      default:                   prdata = '0;
    endcase
  end

  // Input transaction handshake.
  assign in_stall = full;
  assign accept   = in_valid && !full;

  brd_parser u_parser (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .data_byte      (data_byte),
    .start_of_image (start_of_image),
    .last_byte      (last_byte),
    .image_width    (image_width),
    .image_height   (image_height),
    .push           (push),
    .result         (result)
  );

  brd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (result),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  // Result transaction fields.
  assign run_x       = head.run_x;
  assign run_row     = head.run_row;
  assign run_length  = head.run_length;
  assign pixel_index = head.pixel_index;
  assign finished    = head.finished;

endmodule

[verif/testbench.sv]
// Self-checking testbench for bmp_rle8_decoder_top: drives run-length-8 byte streams
// and APB register writes, and predicts every run transaction in a scoreboard class.
// Depends on brd_pkg and the bmp_rle8_decoder_top RTL.
`timescale 1ns / 1ps

// Tracks the decoder state from accepted bytes and holds the runs still owed.
class run_tracker;
  logic [12:0]       width_reg;
  logic [12:0]       height_reg;
  brd_pkg::phase_t   phase;
  logic [12:0]       col;
  logic [12:0]       row;
  logic [7:0]        held;
  logic [7:0]        lit_left;
  bit                pad;
  bit                done;
  brd_pkg::result_t  owed[$];
  int                mismatches;

  function new();
    width_reg  = 13'd1;
    height_reg = 13'd1;
    mismatches = 0;
    clear_image();
  endfunction

  function void clear_image();
    phase    = brd_pkg::PH_COUNT;
    col      = '0;
    row      = '0;
    held     = '0;
    lit_left = '0;
    pad      = 1'b0;
    done     = 1'b0;
  endfunction

  function void set_register(logic idx, logic [12:0] value);
    if (idx == brd_pkg::REG_IMAGE_WIDTH) width_reg = value;
    else height_reg = value;
  endfunction

  function logic [12:0] clamp_dim(logic [12:0] v);
    return (v > 13'(brd_pkg::MAX_DIM)) ? 13'(brd_pkg::MAX_DIM) : v;
  endfunction

  // Cursor moves saturate at the top of the 13-bit range.
  function logic [12:0] bump(logic [12:0] a, logic [7:0] step);
    int s;
    s = int'(a) + int'(step);
    return (s > 8191) ? 13'h1FFF : 13'(s);
  endfunction

  function int runs_owed();
    return owed.size();
  endfunction

  // Advance the parser by one accepted byte and queue the run it produces, if any.
  function void accept_byte(logic [7:0] b, logic sof, logic last);
    logic [12:0]      w;
    logic [12:0]      h;
    logic [12:0]      room;
    logic [12:0]      n;
    brd_pkg::result_t r;
    bit               fin;
    r   = '0;
    fin = 1'b0;
    if (sof) clear_image();
    if (done) return;
    w = clamp_dim(width_reg);
    h = clamp_dim(height_reg);
    if (row >= h) begin
      fin = 1'b1;
    end else begin
      case (phase)
        brd_pkg::PH_COUNT: begin
          held  = b;
          phase = brd_pkg::PH_VALUE;
        end
        brd_pkg::PH_VALUE: begin
          phase = brd_pkg::PH_COUNT;
          if (held != 8'd0) begin
            // Encoded run, clipped at the right edge.
            if (col < w) begin
              room          = w - col;
              n             = ({5'b0, held} < room) ? {5'b0, held} : room;
              r.run_x       = col[11:0];
              r.run_row     = row[11:0];
              r.run_length  = n[7:0];
              r.pixel_index = b;
              col           = col + n;
            end
          end else if (b == brd_pkg::ESC_END_OF_LINE) begin
            col = '0;
            row = bump(row, 8'd1);
            if (row >= h) fin = 1'b1;
          end else if (b == brd_pkg::ESC_END_OF_BITMAP) begin
            fin = 1'b1;
          end else if (b == brd_pkg::ESC_DELTA) begin
            phase = brd_pkg::PH_DX;
          end else begin
            lit_left = b;
            pad      = b[0];
            phase    = brd_pkg::PH_LITERAL;
          end
        end
        brd_pkg::PH_DX: begin
          held  = b;
          phase = brd_pkg::PH_DY;
        end
        brd_pkg::PH_DY: begin
          col   = bump(col, held);
          row   = bump(row, b);
          phase = brd_pkg::PH_COUNT;
          if (row >= h) fin = 1'b1;
        end
        brd_pkg::PH_LITERAL: begin
          if (col < w) begin
            r.run_x       = col[11:0];
            r.run_row     = row[11:0];
            r.run_length  = 8'd1;
            r.pixel_index = b;
            col           = col + 13'd1;
          end
          if (lit_left != 8'd0) lit_left = lit_left - 8'd1;
          if (lit_left == 8'd0) phase = pad ? brd_pkg::PH_PAD : brd_pkg::PH_COUNT;
        end
        default: begin
          pad   = 1'b0;
          phase = brd_pkg::PH_COUNT;
        end
      endcase
    end
    if (last) fin = 1'b1;
    if (fin) done = 1'b1;
    if (r.run_length != 8'd0 || fin) begin
      r.finished = fin;
      owed.insert(owed.size(), r);
    end
  endfunction

  function void report_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Compare one accepted run transaction against the oldest prediction.
  function void check_run(brd_pkg::result_t got);
    brd_pkg::result_t want;
    if (owed.size() == 0) begin
      $display("%0t: unexpected run, expected none, actual x=%0d row=%0d len=%0d pix=%0d fin=%0d",
               $time, got.run_x, got.run_row, got.run_length, got.pixel_index, got.finished);
      mismatches++;
      return;
    end
    want = owed.pop_front();
    report_field("run_x", 32'(want.run_x), 32'(got.run_x));
    report_field("run_row", 32'(want.run_row), 32'(got.run_row));
    report_field("run_length", 32'(want.run_length), 32'(got.run_length));
    report_field("pixel_index", 32'(want.pixel_index), 32'(got.pixel_index));
    report_field("finished", 32'(want.finished), 32'(got.finished));
  endfunction
endclass

module testbench;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_BYTES = 1250;
  localparam int HOLD_CYCLES  = 80;

  typedef struct packed {
    logic [7:0] data;
    logic       sof;
    logic       last;
  } stream_byte_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = '0;
  logic        start_of_image = 1'b0;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [11:0] run_x;
  logic [11:0] run_row;
  logic [7:0]  run_length;
  logic [7:0]  pixel_index;
  logic        finished;

  run_tracker   sb = new();
  stream_byte_t stream_q[$];
  bit           sof_next;
  bit           steady;
  int           bytes_sent;
  int           hold_asks;
  int           holds_done;
  int           cycle_count;

  bmp_rle8_decoder_top dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .data_byte(data_byte),
    .start_of_image(start_of_image), .last_byte(last_byte),
    .out_valid(out_valid), .out_stall(out_stall), .run_x(run_x), .run_row(run_row),
    .run_length(run_length), .pixel_index(pixel_index), .finished(finished)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Both channels are observed in one place so a byte is predicted before its run is checked.
  always @(posedge clk) begin : monitor
    brd_pkg::result_t got;
    if (!rst) begin
      if (in_valid && !in_stall) sb.accept_byte(data_byte, start_of_image, last_byte);
      if (out_valid && !out_stall) begin
        got.run_x       = run_x;
        got.run_row     = run_row;
        got.run_length  = run_length;
        got.pixel_index = pixel_index;
        got.finished    = finished;
        sb.check_run(got);
      end
    end
  end

  // Result side: random stalls per transaction, plus a long hold-off on request.
  initial begin : receiver
    int k;
    forever begin
      if (holds_done < hold_asks) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end else begin
        k = steady ? 0 : $urandom_range(0, 3);
        if (k > 0) begin
          out_stall <= 1'b1;
          repeat (k) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // Register write followed by a read-back, only while the decoder is idle.
  task automatic apb_write(logic idx, logic [12:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {19'b0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    sb.set_register(idx, value);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[12:0] != value) begin
      $display("%0t: register %0d read-back, expected %0d, actual %0d",
               $time, idx, value, prdata[12:0]);
      sb.mismatches++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Stop offering bytes, wait for every owed run, then let the pipeline settle.
  task automatic drain(int extra);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.runs_owed() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  function automatic void push_byte(logic [7:0] b);
    stream_q.insert(stream_q.size(), stream_byte_t'{data: b, sof: sof_next, last: 1'b0});
    sof_next = 1'b0;
  endfunction

  // Offer the queued stream, one transaction per byte, with random gaps and pauses.
  task automatic play_stream();
    int gap;
    bit pause;
    foreach (stream_q[i]) begin
      gap   = steady ? 0 : $urandom_range(0, 3);
      pause = ($urandom_range(0, 99) == 0);
      if (pause && gap == 0) gap = 1;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
        if (pause) while (sb.runs_owed() != 0) @(posedge clk);
      end
      in_valid       <= 1'b1;
      data_byte      <= stream_q[i].data;
      start_of_image <= stream_q[i].sof;
      last_byte      <= stream_q[i].last;
      do @(posedge clk); while (in_stall);
      bytes_sent++;
    end
  endtask

  // Mostly well-formed images with random content, some noise and early stream ends.
  task automatic build_image(int ops);
    int r;
    int len;
    int k;
    stream_q.delete();
    sof_next = 1'b1;
    for (int i = 0; i < ops; i++) begin
      r = $urandom_range(0, 99);
      if (r < 42) begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 16);
        push_byte(len[7:0]);
        push_byte(8'($urandom_range(0, 255)));
      end else if (r < 54) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 255) : $urandom_range(3, 12);
        push_byte(8'd0);
        push_byte(len[7:0]);
        for (k = 0; k < len; k++) push_byte(8'($urandom_range(0, 255)));
        if (len[0]) push_byte(8'($urandom_range(0, 255)));
      end else if (r < 66) begin
        push_byte(8'd0);
        push_byte(brd_pkg::ESC_END_OF_LINE);
      end else if (r < 76) begin
        push_byte(8'd0);
        push_byte(brd_pkg::ESC_DELTA);
        push_byte(8'(($urandom_range(0, 7) == 0) ? 255 : $urandom_range(0, 20)));
        push_byte(8'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                 : $urandom_range(0, 2)));
      end else if (r < 78) begin
        push_byte(8'd0);
        push_byte(brd_pkg::ESC_END_OF_BITMAP);
        break;
      end else if (r < 90) begin
        push_byte(8'($urandom_range(0, 255)));
      end else if (r < 99) begin
        sof_next = 1'b1;
      end else begin
        // Long chain of wide deltas can drive the column cursor into saturation.
        k = $urandom_range(20, 40);
        repeat (k) begin
          push_byte(8'd0);
          push_byte(brd_pkg::ESC_DELTA);
          push_byte(8'd255);
          push_byte(8'd0);
        end
      end
    end
    if (stream_q.size() == 0) push_byte(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 3) == 0 && stream_q.size() > 1) begin
      k = $urandom_range(1, stream_q.size() - 1);
      while (stream_q.size() > k) void'(stream_q.pop_back());
    end
    if ($urandom_range(0, 3) != 0) stream_q[stream_q.size() - 1].last = 1'b1;
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // Register settings per phase: the extremes first, then random ones.
  task automatic pick_config(int p, output logic [12:0] w, output logic [12:0] h);
    case (p)
      0: begin w = 13'd4096; h = 13'd4096; end
      1: begin w = 13'd1;    h = 13'd1;    end
      2: begin w = 13'd8191; h = 13'd8191; end
      3: begin w = 13'd0;    h = 13'd3;    end
      4: begin w = 13'd16;   h = 13'd0;    end
      default: begin
        w = 13'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 4096) : $urandom_range(1, 40));
        h = 13'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 4096) : $urandom_range(1, 12));
      end
    endcase
  endtask

  initial begin : stimulus
    logic [7:0]  directed_bytes [24];
    logic [12:0] w;
    logic [12:0] h;
    int          p;
    int          n_img;
    int          ops;
    bit          tiny;
    // Width 8, height 4: clipped run, empty run, end of line, odd literal with pad,
    // delta, full-width run, end of bitmap.
    directed_bytes = '{8'd5, 8'h11, 8'd10, 8'hEE, 8'd4, 8'h33,
                       8'd0, brd_pkg::ESC_END_OF_LINE,
                       8'd0, 8'd3, 8'hFF, 8'h00, 8'h80, 8'h7F,
                       8'd0, brd_pkg::ESC_DELTA, 8'd6, 8'd1,
                       8'd0, brd_pkg::ESC_END_OF_LINE, 8'd255, 8'hAB,
                       8'd0, brd_pkg::ESC_END_OF_BITMAP};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    apb_write(brd_pkg::REG_IMAGE_WIDTH, 13'd8);
    apb_write(brd_pkg::REG_IMAGE_HEIGHT, 13'd4);

    stream_q.delete();
    sof_next = 1'b1;
    foreach (directed_bytes[i]) push_byte(directed_bytes[i]);
    // A lone stream-end byte finishes with an empty run.
    sof_next = 1'b1;
    push_byte(8'd0);
    stream_q[stream_q.size() - 1].last = 1'b1;
    play_stream();
    drain(4);

    // Random phases, one register setting each.
    bytes_sent = 0;
    p = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      pick_config(p, w, h);
      if (p < 5 || $urandom_range(0, 2) != 0) apb_write(brd_pkg::REG_IMAGE_WIDTH, w);
      if (p < 5 || $urandom_range(0, 2) != 0) apb_write(brd_pkg::REG_IMAGE_HEIGHT, h);
      tiny  = (p == 3 || p == 4);
      n_img = tiny ? 1 : $urandom_range(1, 4);
      for (int i = 0; i < n_img; i++) begin
        ops    = tiny ? $urandom_range(3, 8) : $urandom_range(4, 30);
        steady = ($urandom_range(0, 4) == 0);
        if (p == 0 && i == 0) begin
          // Long receiver hold-off while the sender keeps offering bytes.
          ops    = 60;
          steady = 1'b1;
          hold_asks++;
        end
        build_image(ops);
        play_stream();
      end
      steady = 1'b0;
      drain(4);
      p++;
    end

    drain(10);
    if (sb.mismatches == 0 && sb.runs_owed() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[files.f]
hdl/brd_pkg.sv
hdl/brd_parser.sv
hdl/brd_queue.sv
hdl/bmp_rle8_decoder_top.sv
verif/testbench.sv
